/* src/pprgb_pkg.sv */
// ----------------------------------------------------------------------------
// pprgb_pkg: shared types and helpers for the packed pixel to RGB888 block
// Format codes, byte counts per format, the gathered-pixel record and the
// channel scaling function.
// ----------------------------------------------------------------------------
package pprgb_pkg;

  // Pixel format codes; 11..15 are unused and consume bytes without output.
  typedef enum logic [3:0] {
    FMT_RGB332   = 4'd0,
    FMT_XRGB444  = 4'd1,
    FMT_XRGB555  = 4'd2,
    FMT_RGB565   = 4'd3,
    FMT_XRGB555X = 4'd4,
    FMT_RGB565X  = 4'd5,
    FMT_BGR24    = 4'd6,
    FMT_RGB24    = 4'd7,
    FMT_BGR666   = 4'd8,
    FMT_XBGR32   = 4'd9,
    FMT_XRGB32   = 4'd10
  } fmt_t;

  localparam logic [3:0] FORMAT_COUNT = 4'd11;

  // One complete pixel, byte k of the pixel in bytes[k].
  typedef struct packed {
    logic [3:0]      format;
    logic [3:0][7:0] bytes;
  } pix_t;

  function automatic logic [2:0] bytes_per_pixel(input logic [3:0] fmt);
    logic [2:0] n;
    case (fmt)
      FMT_RGB332:                               n = 3'd1;
      FMT_XRGB444, FMT_XRGB555, FMT_RGB565,
      FMT_XRGB555X, FMT_RGB565X:                n = 3'd2;
      FMT_BGR24, FMT_RGB24, FMT_BGR666:         n = 3'd3;
      FMT_XBGR32, FMT_XRGB32:                   n = 3'd4;
      default:                                  n = 3'd1;
    endcase
    return n;
  endfunction

  // floor(v*255/(2^bits-1)) as v*C >> 16, C = ceil(255*2^16/(2^bits-1)).
  // Rounding error stays far below 1/(2^bits-1), so the floor is exact.
  function automatic logic [7:0] scale_chan(input logic [7:0] v, input logic [3:0] bits);
    logic [22:0] mult;
    logic [30:0] prod;
    case (bits)
      4'd2:    mult = 23'd5570560;
      4'd3:    mult = 23'd2387383;
      4'd4:    mult = 23'd1114112;
      4'd5:    mult = 23'd539087;
      4'd6:    mult = 23'd265265;
      default: mult = 23'd65536;
    endcase
    prod = 31'(v) * 31'(mult);
    return prod[23:16];
  endfunction

endpackage

/* src/pprgb_gather.sv */
// ----------------------------------------------------------------------------
// pprgb_gather: byte collection front end
// Holds the format register, tracks the byte position inside the current
// pixel and registers each completed pixel for the conversion stage.
// ----------------------------------------------------------------------------
module pprgb_gather (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [3:0]      cfg_wr_data,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // data_byte
  input  logic            s_tlast,   // last_byte
  output logic            pix_valid,
  output pprgb_pkg::pix_t pix,
  input  logic            pix_ready
);
  import pprgb_pkg::*;

  logic [3:0]      pixel_format;
  logic [1:0]      byte_position;
  logic [2:0][7:0] held_bytes;

  logic [2:0] size;
  logic       fmt_ok;
  logic       accept;
  logic       complete;
  pix_t       pix_next;

  always_comb begin
    size     = bytes_per_pixel(pixel_format);
    fmt_ok   = pixel_format < FORMAT_COUNT;
    s_tready = !pix_valid || pix_ready;
    accept   = s_tvalid && s_tready;
    complete = fmt_ok && (({1'b0, byte_position} + 3'd1) >= size);

    pix_next.format   = pixel_format;
    pix_next.bytes[0] = held_bytes[0];
    pix_next.bytes[1] = held_bytes[1];
    pix_next.bytes[2] = held_bytes[2];
    pix_next.bytes[3] = 8'd0;
    pix_next.bytes[2'(size - 3'd1)] = s_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format  <= FMT_RGB24;
      byte_position <= 2'd0;
      pix_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pixel_format <= cfg_wr_data;
      end

      if (cfg_wr_en) begin
        byte_position <= 2'd0;
      end else if (accept) begin
        if (!fmt_ok || complete || s_tlast) begin
          byte_position <= 2'd0;
        end else begin
          byte_position <= byte_position + 2'd1;
        end
      end

      if (accept && complete) begin
        pix_valid <= 1'b1;
      end else if (pix_ready) begin
        pix_valid <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept && fmt_ok && !complete) begin
      held_bytes[byte_position] <= s_tdata;
    end
    if (accept && complete) begin
      pix <= pix_next;
    end
  end

`ifndef SYNTHESIS
  // position never reaches the pixel size of a valid format
  assert property (@(posedge clk) disable iff (rst)
    fmt_ok |-> ({1'b0, byte_position} < size))
    else $error("byte position beyond pixel size");

  // unused formats keep the position at zero
  assert property (@(posedge clk) disable iff (rst)
    !fmt_ok |-> (byte_position == 2'd0))
    else $error("byte position moved under unused format");

  // a last byte always ends the current pixel
  assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (byte_position == 2'd0))
    else $error("pixel not discarded after last byte");
`endif

endmodule

/* src/pprgb_convert.sv */
// ----------------------------------------------------------------------------
// pprgb_convert: channel extraction and scaling
// Cuts the three channels out of a gathered pixel, scales each to eight bits
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module pprgb_convert (
  input  logic            clk,
  input  logic            rst,
  input  logic            pix_valid,
  input  pprgb_pkg::pix_t pix,
  output logic            pix_ready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [23:0]     m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);
  import pprgb_pkg::*;

  logic [7:0] b0, b1, b2, b3;
  logic [7:0] r, g, bl;
  logic [3:0] rn, gn, bn;

  always_comb begin
    b0 = pix.bytes[0];
    b1 = pix.bytes[1];
    b2 = pix.bytes[2];
    b3 = pix.bytes[3];
    case (pix.format)
      FMT_RGB332: begin
        r = 8'(b0[7:5]); g = 8'(b0[4:2]); bl = 8'(b0[1:0]);
        rn = 4'd3; gn = 4'd3; bn = 4'd2;
      end
      FMT_XRGB444: begin
        r = 8'(b1[3:0]); g = 8'(b0[7:4]); bl = 8'(b0[3:0]);
        rn = 4'd4; gn = 4'd4; bn = 4'd4;
      end
      FMT_XRGB555: begin
        r = 8'(b1[6:2]); g = 8'({b1[1:0], b0[7:5]}); bl = 8'(b0[4:0]);
        rn = 4'd5; gn = 4'd5; bn = 4'd5;
      end
      FMT_RGB565: begin
        r = 8'(b1[7:3]); g = 8'({b1[2:0], b0[7:5]}); bl = 8'(b0[4:0]);
        rn = 4'd5; gn = 4'd6; bn = 4'd5;
      end
      FMT_XRGB555X: begin
        r = 8'(b0[6:2]); g = 8'({b0[1:0], b1[7:5]}); bl = 8'(b1[4:0]);
        rn = 4'd5; gn = 4'd5; bn = 4'd5;
      end
      FMT_RGB565X: begin
        r = 8'(b0[7:3]); g = 8'({b0[2:0], b1[7:5]}); bl = 8'(b1[4:0]);
        rn = 4'd5; gn = 4'd6; bn = 4'd5;
      end
      FMT_BGR24, FMT_XBGR32: begin
        r = b2; g = b1; bl = b0;
        rn = 4'd8; gn = 4'd8; bn = 4'd8;
      end
      FMT_RGB24: begin
        r = b0; g = b1; bl = b2;
        rn = 4'd8; gn = 4'd8; bn = 4'd8;
      end
      FMT_BGR666: begin
        r = 8'({b1[3:0], b2[7:6]}); g = 8'({b0[1:0], b1[7:4]}); bl = 8'(b0[7:2]);
        rn = 4'd6; gn = 4'd6; bn = 4'd6;
      end
      default: begin
        r = b1; g = b2; bl = b3;
        rn = 4'd8; gn = 4'd8; bn = 4'd8;
      end
    endcase
    pix_ready = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pix_valid && pix_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && pix_ready) begin
      m_tdata <= {scale_chan(bl, bn), scale_chan(g, gn), scale_chan(r, rn)};
    end
  end

`ifndef SYNTHESIS
  // a stalled pixel waits unchanged in the gather register
  assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !pix_ready) |=> (pix_valid && $stable(pix)))
    else $error("stalled pixel lost or changed");
`endif

endmodule

/* src/packed_pixel_to_rgb888.sv */
// ----------------------------------------------------------------------------
// packed_pixel_to_rgb888: packed pixel byte stream to RGB888
// Gathers the 1 to 4 bytes of a packed pixel and emits one RGB888 transfer.
// ----------------------------------------------------------------------------
// The block takes one byte per clock and sustains that rate for as long as
// m_tready keeps both pipeline registers draining; a pixel is 1 byte for
// RGB332, 2 for the 16-bit formats, 3 for the 24-bit and BGR666 formats and
// 4 for the 32-bit formats. The completed pixel is held in the gather
// register, then its result in the output register, with the field
// extraction and the three constant multiplies in between. Each channel
// of n bits is scaled to floor(v*255/(2^n-1)); 8-bit channels pass unchanged.
// The format is set through cfg_wr_en/cfg_wr_data (codes 0..10: RGB332,
// XRGB444, XRGB555, RGB565, XRGB555X, RGB565X, BGR24, RGB24, BGR666, XBGR32,
// XRGB32; reset RGB24). Write it only while the block is idle; a write drops
// any partly gathered pixel. Codes 11..15 swallow every byte and produce
// nothing. A byte with s_tlast set that does not finish a pixel discards the
// partial pixel. Both pipeline registers advance whenever their consumer is
// ready, so back-pressure on m_tready stalls s_tready only once both fill.
// ----------------------------------------------------------------------------
module packed_pixel_to_rgb888 (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,  // pixel_format
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // [7:0] data_byte
  input  logic        s_tlast,      // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata       // [7:0] red, [15:8] green, [23:16] blue
);
  import pprgb_pkg::*;

  // completed pixel handed from gather to convert
  logic pix_valid;
  logic pix_ready;
  pix_t pix;

  // byte position, held bytes, format register
  pprgb_gather u_gather (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .pix_valid   (pix_valid),
    .pix         (pix),
    .pix_ready   (pix_ready)
  );

  // field cut, scaling, output register
  pprgb_convert u_convert (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix       (pix),
    .pix_ready (pix_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

`ifndef SYNTHESIS
  // a result that is not taken stays offered
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result withdrawn before transfer");
`endif

endmodule

/* verif/pprgb_checker.sv */
// ----------------------------------------------------------------------------
// pprgb_checker: pixel predictor and output checker for packed_pixel_to_rgb888
// Watches the format writes and both stream channels, predicts the RGB888
// pixel of every completed input pixel and compares each output transfer
// against the oldest predicted pixel.
// ----------------------------------------------------------------------------
module pprgb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int          outstanding,  // predicted pixels not yet seen
  output int          fail_count
);
  import pprgb_pkg::*;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  rgb_t       pixel_q[$];
  rgb_t       want;
  rgb_t       got;
  logic [3:0] cur_fmt;
  int         byte_idx;
  logic [7:0] held[3];
  logic [7:0] pix[4];
  int         errors = 0;

  function automatic int pixel_bytes(input logic [3:0] fmt);
    case (fmt)
      FMT_RGB332:                        return 1;
      FMT_BGR24, FMT_RGB24, FMT_BGR666:  return 3;
      FMT_XBGR32, FMT_XRGB32:            return 4;
      default:                           return 2;
    endcase
  endfunction

  // floor(v*255/(2^n-1)); exact integer division, 8-bit channels unchanged
  function automatic logic [7:0] expand_to_8(input logic [7:0] v, input int n);
    int unsigned full;
    full = (32'd1 << n) - 1;
    return 8'((32'(v) * 255) / full);
  endfunction

  function automatic rgb_t predict_pixel(input logic [3:0] fmt,
                                         input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3);
    rgb_t px;
    case (fmt)
      FMT_RGB332: begin
        px.red   = expand_to_8(8'(b0[7:5]), 3);
        px.green = expand_to_8(8'(b0[4:2]), 3);
        px.blue  = expand_to_8(8'(b0[1:0]), 2);
      end
      FMT_XRGB444: begin
        px.red   = expand_to_8(8'(b1[3:0]), 4);
        px.green = expand_to_8(8'(b0[7:4]), 4);
        px.blue  = expand_to_8(8'(b0[3:0]), 4);
      end
      FMT_XRGB555: begin
        px.red   = expand_to_8(8'(b1[6:2]), 5);
        px.green = expand_to_8(8'({b1[1:0], b0[7:5]}), 5);
        px.blue  = expand_to_8(8'(b0[4:0]), 5);
      end
      FMT_RGB565: begin
        px.red   = expand_to_8(8'(b1[7:3]), 5);
        px.green = expand_to_8(8'({b1[2:0], b0[7:5]}), 6);
        px.blue  = expand_to_8(8'(b0[4:0]), 5);
      end
      FMT_XRGB555X: begin
        px.red   = expand_to_8(8'(b0[6:2]), 5);
        px.green = expand_to_8(8'({b0[1:0], b1[7:5]}), 5);
        px.blue  = expand_to_8(8'(b1[4:0]), 5);
      end
      FMT_RGB565X: begin
        px.red   = expand_to_8(8'(b0[7:3]), 5);
        px.green = expand_to_8(8'({b0[2:0], b1[7:5]}), 6);
        px.blue  = expand_to_8(8'(b1[4:0]), 5);
      end
      FMT_RGB24: begin
        px.red = b0; px.green = b1; px.blue = b2;
      end
      FMT_BGR666: begin
        px.red   = expand_to_8(8'({b1[3:0], b2[7:6]}), 6);
        px.green = expand_to_8(8'({b0[1:0], b1[7:4]}), 6);
        px.blue  = expand_to_8(8'(b0[7:2]), 6);
      end
      FMT_XRGB32: begin
        px.red = b1; px.green = b2; px.blue = b3;
      end
      default: begin  // BGR24, XBGR32
        px.red = b2; px.green = b1; px.blue = b0;
      end
    endcase
    return px;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cur_fmt  = FMT_RGB24;
      byte_idx = 0;
      held     = '{default: 8'h00};
      pixel_q.delete();
    end else begin
      // a format write drops any partly gathered pixel
      if (cfg_wr_en) begin
        cur_fmt  = cfg_wr_data;
        byte_idx = 0;
      end

      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pixel_q.size() == 0) begin
          $error("output transfer with no pixel pending: m_tdata %h", m_tdata);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          if (got.red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, got.red);
            errors++;
          end
          if (got.green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, got.green);
            errors++;
          end
          if (got.blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, got.blue);
            errors++;
          end
        end
      end

      if (s_tvalid && s_tready) begin
        if (cur_fmt >= FORMAT_COUNT) begin
          byte_idx = 0;  // unused code swallows the byte
        end else if (byte_idx + 1 < pixel_bytes(cur_fmt)) begin
          held[byte_idx] = s_tdata;
          byte_idx = s_tlast ? 0 : byte_idx + 1;
        end else begin
          pix = '{held[0], held[1], held[2], 8'h00};
          pix[pixel_bytes(cur_fmt) - 1] = s_tdata;
          pixel_q.push_back(predict_pixel(cur_fmt, pix[0], pix[1], pix[2], pix[3]));
          byte_idx = 0;
        end
      end
    end
    outstanding <= pixel_q.size();
    fail_count  <= errors;
  end

endmodule

/* verif/tb_packed_pixel_to_rgb888.sv */
// ----------------------------------------------------------------------------
// tb_packed_pixel_to_rgb888: regression for the packed pixel to RGB888 block
// Directed pixels for the reset format, extremes, partial pixels, unused
// codes and a mid-pixel format change, then random byte streams over all
// format codes with bursty input, stalling output and long output hold-offs.
// Checking lives in pprgb_checker; this top drives stimulus and the verdict.
// ----------------------------------------------------------------------------
module tb_packed_pixel_to_rgb888;
  import pprgb_pkg::*;

  localparam int         RANDOM_BYTES  = 1100;
  localparam int         DRAIN_CYCLES  = 6;    // two-stage pipe plus margin
  localparam int         LONG_HOLD     = 300;  // output hold-off, in cycles
  localparam logic [3:0] FMT_TOP_CODE  = 4'hF; // highest (unused) format code

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_wr_en   = 1'b0;
  logic [3:0]  cfg_wr_data = '0;
  logic        s_tvalid    = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata     = '0;
  logic        s_tlast     = 1'b0;
  logic        m_tvalid;
  logic        m_tready    = 1'b0;
  logic [23:0] m_tdata;

  int outstanding;
  int fail_count;
  int burst_left    = 0;  // transfers left in the current input burst
  int hold_off_reqs = 0;  // bumped by stimulus, served by the output side

  always #10 clk = ~clk;

  packed_pixel_to_rgb888 dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  pprgb_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  // Offer one byte and hold it until the transfer. Between bursts tvalid
  // drops for a random gap, so gaps land at any byte position of a pixel.
  task automatic push_byte(input logic [7:0] value, input logic last);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  // Format writes only go in once the pipe is empty. Partial pixels and
  // unused codes leave nothing pending, so sit out the pipe depth as well.
  task automatic set_format(input logic [3:0] fmt);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= fmt;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly random bytes, with all-zero and all-one bytes on the side.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Output side: spans of always-ready, coin-flip, mostly-stalled and a
  // fixed 3-of-4 pattern; a hold-off request cuts the span short and parks
  // tready low for LONG_HOLD.
  initial begin
    int mode;
    int span;
    int tick;
    int served;
    served = 0;
    tick   = 0;
    forever begin
      if (hold_off_reqs != served) begin
        served = hold_off_reqs;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        if (hold_off_reqs != served) break;
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 1) != 0);
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (tick % 4 != 3);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  initial begin
    int         phase;
    int         count;
    int         random_sent;
    logic [3:0] fmt;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset format is RGB24: one pixel of mixed extremes
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h5A, 1'b0);
    // partial pixel at a last byte is dropped
    push_byte(8'hFF, 1'b0);
    push_byte(8'h81, 1'b1);
    // last byte on the completing byte still yields the pixel
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'hFF, 1'b1);

    // one-byte pixels: full scale, zero, and a last flag on a whole pixel
    set_format(FMT_RGB332);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h6D, 1'b0);

    set_format(FMT_RGB565);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);

    // first unused code: bytes vanish
    set_format(FORMAT_COUNT);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);

    // format change with a pixel half gathered: that byte is lost
    set_format(FMT_BGR666);
    push_byte(8'hC3, 1'b0);
    set_format(FMT_XRGB32);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);

    // Random phases: first sweep all 16 codes in order, then random codes
    // weighted toward valid formats. Unused-code bytes are not counted.
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_BYTES) begin
      if (phase < 16)
        fmt = 4'(phase);
      else if ($urandom_range(0, 7) == 0)
        fmt = 4'($urandom_range(FORMAT_COUNT, FMT_TOP_CODE));
      else
        fmt = 4'($urandom_range(FMT_RGB332, FMT_XRGB32));
      set_format(fmt);

      if (fmt >= FORMAT_COUNT) begin
        count = 8;
      end else if (phase == 5 || phase == 9) begin
        // long output hold-off while input streams without gaps
        count = 80;
        burst_left = 200;
        hold_off_reqs++;
      end else begin
        count = $urandom_range(20, 90);
      end

      repeat (count) begin
        push_byte(pick_byte(), $urandom_range(0, 15) == 0);
        if (fmt < FORMAT_COUNT) random_sent++;
      end
      phase++;
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("packed_pixel_to_rgb888 regression: pass");
    end else begin
      $display("packed_pixel_to_rgb888 regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #8000000;
    $display("packed_pixel_to_rgb888 regression: fail");
    $finish;
  end

endmodule
